// ----- hdl/ssd_pkg.sv -----
// shared widths, constants and arithmetic helpers for the segment distance pipeline
// no dependencies

package ssd_pkg;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int DOT_W      = 2 * COORD_W + 3;
   localparam int CROSS_W    = 2 * DOT_W;
   localparam int WIDE_W     = CROSS_W + 2;
   localparam int FRAC_W     = 32;
   localparam int PARAM_W    = FRAC_W + 1;
   localparam int DP_W       = COORD_W + FRAC_W + 3;
   localparam int MAG_W      = COORD_W + FRAC_W + 2;
   localparam int LO_W       = 26;
   localparam int HI_W       = MAG_W - LO_W;
   localparam int SQ_W       = 2 * MAG_W + 2;
   localparam int DIST_W     = 34;
   localparam int EPS_W      = 16;
   localparam int EPS_SHIFT  = 16;
   localparam int PIPE_DEPTH = 8 + FRAC_W + 6;

   localparam logic [EPS_W-1:0]  EPS_RESET = 16'd66;
   localparam logic [DIST_W-1:0] DIST_MAX  = 34'd12884901888;

   // dot product slots
   localparam int DOT_UU = 0;
   localparam int DOT_UV = 1;
   localparam int DOT_VV = 2;
   localparam int DOT_UW = 3;
   localparam int DOT_VW = 4;
   localparam int DOTS   = 5;

   // cross product slots
   localparam int X_UUVV = 0;
   localparam int X_UVUV = 1;
   localparam int X_UVVW = 2;
   localparam int X_VVUW = 3;
   localparam int X_UUVW = 4;
   localparam int X_UVUW = 5;
   localparam int CROSSES = 6;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] u;
      logic [2:0][DIFF_W-1:0] v;
      logic [2:0][DIFF_W-1:0] w;
   } geo_type;

   typedef struct packed {
      logic [WIDE_W-1:0] rem;
      logic [WIDE_W-1:0] den;
      logic [FRAC_W-1:0] quo;
      logic              one;
   } lane_type;

   typedef struct packed {
      lane_type s;
      lane_type t;
      geo_type  g;
   } div_type;

   function automatic logic near_zero(logic signed [WIDE_W-1:0] x, logic [EPS_W-1:0] eps);
      logic [WIDE_W-1:0] mag;
      logic [WIDE_W-1:0] lim;
      mag = x[WIDE_W-1] ? -x : x;
      lim = {{(WIDE_W-EPS_W-EPS_SHIFT){1'b0}}, eps, {EPS_SHIFT{1'b0}}};
      return mag <= lim;
   endfunction

   function automatic lane_type param_prep(logic signed [WIDE_W-1:0] num,
                                           logic signed [WIDE_W-1:0] den,
                                           logic [EPS_W-1:0] eps);
      lane_type r;
      r.rem = '0;
      r.den = {{(WIDE_W-1){1'b0}}, 1'b1};
      r.quo = '0;
      r.one = 1'b0;
      if (near_zero(num, eps) || num[WIDE_W-1] || den[WIDE_W-1] || den == '0) begin
         r.one = 1'b0;
      end else if (num >= den) begin
         r.one = 1'b1;
      end else begin
         r.rem = num;
         r.den = den;
      end
      return r;
   endfunction

   function automatic lane_type div_step(lane_type l);
      lane_type r;
      logic [WIDE_W-1:0] r2;
      r  = l;
      r2 = {l.rem[WIDE_W-2:0], 1'b0};
      if (r2 >= l.den) begin
         r.rem = r2 - l.den;
         r.quo = {l.quo[FRAC_W-2:0], 1'b1};
      end else begin
         r.rem = r2;
         r.quo = {l.quo[FRAC_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- hdl/segment_segment_distance_sq.sv -----
// squared closest distance between two 3d segments, fully pipelined
// one item per cycle while the output is not stalled
// 8 setup stages, 32 one-bit divider stages for s and t, 6 distance stages
// a stall at the output freezes the whole pipe, nothing is dropped or repeated
// synchronous reset clears all valid bits and loads the threshold with 66
// depends on ssd_pkg

module segment_segment_distance_sq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_a_start_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_a_start_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_a_start_z,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_a_end_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_a_end_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_a_end_z,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_b_start_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_b_start_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_b_start_z,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_b_end_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_b_end_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_b_end_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssd_pkg::DIST_W-1:0]      rsp_dist_sq,
   input  logic                            csr_wr_en,
   input  logic [ssd_pkg::EPS_W-1:0]       csr_wr_data
);

   localparam int C  = ssd_pkg::COORD_W;
   localparam int DW = ssd_pkg::DIFF_W;
   localparam int WW = ssd_pkg::WIDE_W;
   localparam int FW = ssd_pkg::FRAC_W;
   localparam int XW = ssd_pkg::DOT_W + 1;
   localparam int DIV_VALID = 8 + FW - 1;

   logic [ssd_pkg::EPS_W-1:0]      eps_ff;
   logic [ssd_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic                           en;

   logic signed [C-1:0] a_s [3];
   logic signed [C-1:0] a_e [3];
   logic signed [C-1:0] b_s [3];
   logic signed [C-1:0] b_e [3];

   ssd_pkg::geo_type geo_in;
   ssd_pkg::geo_type geo_ff [7];

   logic signed [ssd_pkg::PROD_W-1:0]  prod_in [ssd_pkg::DOTS][3];
   logic signed [ssd_pkg::PROD_W-1:0]  prod_ff [ssd_pkg::DOTS][3];
   logic signed [ssd_pkg::DOT_W-1:0]   dot_in  [ssd_pkg::DOTS];
   logic signed [ssd_pkg::DOT_W-1:0]   dot_ff  [ssd_pkg::DOTS];
   logic signed [ssd_pkg::DOT_W-1:0]   dot4_ff [ssd_pkg::DOTS];
   logic signed [ssd_pkg::DOT_W-1:0]   dot5_ff [ssd_pkg::DOTS];
   logic signed [ssd_pkg::DOT_W-1:0]   dot6_ff [ssd_pkg::DOTS];
   logic signed [ssd_pkg::CROSS_W-1:0] cross_in [ssd_pkg::CROSSES];
   logic signed [ssd_pkg::CROSS_W-1:0] cross_ff [ssd_pkg::CROSSES];

   logic signed [WW-1:0] den_in, sn_in, tn_in;
   logic signed [WW-1:0] den_ff, sn_ff, tn_ff;
   logic signed [WW-1:0] sn6_in, sd6_in, tn6_in, td6_in;
   logic signed [WW-1:0] sn6_ff, sd6_ff, tn6_ff, td6_ff;
   logic signed [WW-1:0] sn7_in, sd7_in, tn7_in, td7_in;
   logic signed [WW-1:0] sn7_ff, sd7_ff, tn7_ff, td7_ff;

   ssd_pkg::div_type div_in [FW+1];
   ssd_pkg::div_type div_ff [FW+1];

   logic signed [ssd_pkg::DP_W-1:0]  su_in [3];
   logic signed [ssd_pkg::DP_W-1:0]  tv_in [3];
   logic signed [ssd_pkg::DP_W-1:0]  su_ff [3];
   logic signed [ssd_pkg::DP_W-1:0]  tv_ff [3];
   logic [2:0][DW-1:0]               wa_ff;
   logic [ssd_pkg::MAG_W-1:0]        mag_in [3];
   logic [ssd_pkg::MAG_W-1:0]        mag_ff [3];
   logic [2*ssd_pkg::HI_W-1:0]       hh_ff [3];
   logic [ssd_pkg::MAG_W-1:0]        hl_ff [3];
   logic [2*ssd_pkg::LO_W-1:0]       ll_ff [3];
   logic [ssd_pkg::SQ_W-1:0]         sq_in [3];
   logic [ssd_pkg::SQ_W-1:0]         sq_ff [3];
   logic [ssd_pkg::SQ_W-1:0]         sum_in;
   logic [ssd_pkg::SQ_W-1:0]         sum_ff;
   logic [ssd_pkg::DIST_W-1:0]       dist_in;
   logic [ssd_pkg::DIST_W-1:0]       dist_ff;

   assign en        = !valid_ff[ssd_pkg::PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[ssd_pkg::PIPE_DEPTH-1];
   assign rsp_dist_sq = dist_ff;

   assign a_s[0] = req_a_start_x;
   assign a_s[1] = req_a_start_y;
   assign a_s[2] = req_a_start_z;
   assign a_e[0] = req_a_end_x;
   assign a_e[1] = req_a_end_y;
   assign a_e[2] = req_a_end_z;
   assign b_s[0] = req_b_start_x;
   assign b_s[1] = req_b_start_y;
   assign b_s[2] = req_b_start_z;
   assign b_e[0] = req_b_end_x;
   assign b_e[1] = req_b_end_y;
   assign b_e[2] = req_b_end_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= ssd_pkg::EPS_RESET;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
         if (en) begin
            valid_ff <= {valid_ff[ssd_pkg::PIPE_DEPTH-2:0], req_valid};
         end
      end
   end

   // stage 1: edge vectors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         geo_in.u[i] = {a_e[i][C-1], a_e[i]} - {a_s[i][C-1], a_s[i]};
         geo_in.v[i] = {b_e[i][C-1], b_e[i]} - {b_s[i][C-1], b_s[i]};
         geo_in.w[i] = {a_s[i][C-1], a_s[i]} - {b_s[i][C-1], b_s[i]};
      end
   end

   // stage 2: per-axis products
   always_comb begin
      logic signed [DW-1:0] ux, vx, wx;
      ux = '0;
      vx = '0;
      wx = '0;
      for (int i = 0; i < 3; i++) begin
         ux = $signed(geo_ff[0].u[i]);
         vx = $signed(geo_ff[0].v[i]);
         wx = $signed(geo_ff[0].w[i]);
         prod_in[ssd_pkg::DOT_UU][i] = ux * ux;
         prod_in[ssd_pkg::DOT_UV][i] = ux * vx;
         prod_in[ssd_pkg::DOT_VV][i] = vx * vx;
         prod_in[ssd_pkg::DOT_UW][i] = ux * wx;
         prod_in[ssd_pkg::DOT_VW][i] = vx * wx;
      end
   end

   // stage 3: dot products
   always_comb begin
      for (int j = 0; j < ssd_pkg::DOTS; j++) begin
         dot_in[j] = ssd_pkg::DOT_W'(prod_ff[j][0]) + ssd_pkg::DOT_W'(prod_ff[j][1])
                   + ssd_pkg::DOT_W'(prod_ff[j][2]);
      end
   end

   // stage 4: cross terms
   always_comb begin
      cross_in[ssd_pkg::X_UUVV] = dot_ff[ssd_pkg::DOT_UU] * dot_ff[ssd_pkg::DOT_VV];
      cross_in[ssd_pkg::X_UVUV] = dot_ff[ssd_pkg::DOT_UV] * dot_ff[ssd_pkg::DOT_UV];
      cross_in[ssd_pkg::X_UVVW] = dot_ff[ssd_pkg::DOT_UV] * dot_ff[ssd_pkg::DOT_VW];
      cross_in[ssd_pkg::X_VVUW] = dot_ff[ssd_pkg::DOT_VV] * dot_ff[ssd_pkg::DOT_UW];
      cross_in[ssd_pkg::X_UUVW] = dot_ff[ssd_pkg::DOT_UU] * dot_ff[ssd_pkg::DOT_VW];
      cross_in[ssd_pkg::X_UVUW] = dot_ff[ssd_pkg::DOT_UV] * dot_ff[ssd_pkg::DOT_UW];
   end

   // stage 5: denominator and raw numerators
   always_comb begin
      den_in = WW'(cross_ff[ssd_pkg::X_UUVV]) - WW'(cross_ff[ssd_pkg::X_UVUV]);
      sn_in  = WW'(cross_ff[ssd_pkg::X_UVVW]) - WW'(cross_ff[ssd_pkg::X_VVUW]);
      tn_in  = WW'(cross_ff[ssd_pkg::X_UUVW]) - WW'(cross_ff[ssd_pkg::X_UVUW]);
   end

   // stage 6: parallel case and s clamp
   always_comb begin
      logic signed [WW-1:0] vw_sh, vv_sh, vwuv_sh;
      vw_sh   = WW'(dot5_ff[ssd_pkg::DOT_VW]) <<< ssd_pkg::EPS_SHIFT;
      vv_sh   = WW'(dot5_ff[ssd_pkg::DOT_VV]) <<< ssd_pkg::EPS_SHIFT;
      vwuv_sh = (WW'(dot5_ff[ssd_pkg::DOT_VW]) + WW'(dot5_ff[ssd_pkg::DOT_UV]))
                <<< ssd_pkg::EPS_SHIFT;
      priority if (ssd_pkg::near_zero(den_ff, eps_ff)) begin
         sn6_in = '0;
         sd6_in = {{(WW-FW-1){1'b0}}, 1'b1, {FW{1'b0}}};
         tn6_in = vw_sh;
         td6_in = vv_sh;
      end else if (sn_ff[WW-1]) begin
         sn6_in = '0;
         sd6_in = den_ff;
         tn6_in = vw_sh;
         td6_in = vv_sh;
      end else if (sn_ff > den_ff) begin
         sn6_in = den_ff;
         sd6_in = den_ff;
         tn6_in = vwuv_sh;
         td6_in = vv_sh;
      end else begin
         sn6_in = sn_ff;
         sd6_in = den_ff;
         tn6_in = tn_ff;
         td6_in = den_ff;
      end
   end

   // stage 7: t clamp and s recompute
   always_comb begin
      logic signed [XW-1:0] x1, x2, uu, xs;
      logic                 adj;
      x1  = -XW'(dot6_ff[ssd_pkg::DOT_UW]);
      x2  = XW'(dot6_ff[ssd_pkg::DOT_UV]) - XW'(dot6_ff[ssd_pkg::DOT_UW]);
      uu  = XW'(dot6_ff[ssd_pkg::DOT_UU]);
      sn7_in = sn6_ff;
      sd7_in = sd6_ff;
      tn7_in = tn6_ff;
      td7_in = td6_ff;
      adj = 1'b1;
      xs  = x1;
      priority if (tn6_ff[WW-1]) begin
         tn7_in = '0;
         xs     = x1;
      end else if (tn6_ff > td6_ff) begin
         tn7_in = td6_ff;
         xs     = x2;
      end else begin
         adj = 1'b0;
      end
      if (adj) begin
         priority if (xs[XW-1]) begin
            sn7_in = '0;
         end else if (xs > uu) begin
            sn7_in = sd6_ff;
         end else begin
            sn7_in = WW'(xs) <<< ssd_pkg::EPS_SHIFT;
            sd7_in = WW'(uu) <<< ssd_pkg::EPS_SHIFT;
         end
      end
   end

   // stage 8 and divider stages
   always_comb begin
      div_in[0].s = ssd_pkg::param_prep(sn7_ff, sd7_ff, eps_ff);
      div_in[0].t = ssd_pkg::param_prep(tn7_ff, td7_ff, eps_ff);
      div_in[0].g = geo_ff[6];
      for (int k = 1; k <= FW; k++) begin
         div_in[k].s = ssd_pkg::div_step(div_ff[k-1].s);
         div_in[k].t = ssd_pkg::div_step(div_ff[k-1].t);
         div_in[k].g = div_ff[k-1].g;
      end
   end

   // stage a: parameter times edge
   always_comb begin
      logic [ssd_pkg::PARAM_W-1:0] sq, tq;
      sq = div_ff[FW].s.one ? {1'b1, {FW{1'b0}}} : {1'b0, div_ff[FW].s.quo};
      tq = div_ff[FW].t.one ? {1'b1, {FW{1'b0}}} : {1'b0, div_ff[FW].t.quo};
      for (int i = 0; i < 3; i++) begin
         su_in[i] = $signed({1'b0, sq}) * $signed(div_ff[FW].g.u[i]);
         tv_in[i] = $signed({1'b0, tq}) * $signed(div_ff[FW].g.v[i]);
      end
   end

   // stage b: distance vector magnitude
   always_comb begin
      logic signed [ssd_pkg::DP_W-1:0] dp;
      dp = '0;
      for (int i = 0; i < 3; i++) begin
         dp = (ssd_pkg::DP_W'($signed(wa_ff[i])) <<< FW) + su_ff[i] - tv_ff[i];
         mag_in[i] = dp[ssd_pkg::DP_W-1] ? ssd_pkg::MAG_W'(-dp) : ssd_pkg::MAG_W'(dp);
      end
   end

   // stage d and e: squares and sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (ssd_pkg::SQ_W'(hh_ff[i]) << (2 * ssd_pkg::LO_W))
                  + (ssd_pkg::SQ_W'(hl_ff[i]) << (ssd_pkg::LO_W + 1))
                  + ssd_pkg::SQ_W'(ll_ff[i]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // stage f: scale and saturate
   always_comb begin
      logic [ssd_pkg::SQ_W-2*FW-1:0] val;
      val = sum_ff[ssd_pkg::SQ_W-1:2*FW];
      if (val >= (ssd_pkg::SQ_W-2*FW)'(ssd_pkg::DIST_MAX)) begin
         dist_in = ssd_pkg::DIST_MAX;
      end else begin
         dist_in = val[ssd_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo_ff[0] <= geo_in;
         for (int k = 1; k < 7; k++) begin
            geo_ff[k] <= geo_ff[k-1];
         end
         prod_ff  <= prod_in;
         dot_ff   <= dot_in;
         dot4_ff  <= dot_ff;
         dot5_ff  <= dot4_ff;
         dot6_ff  <= dot5_ff;
         cross_ff <= cross_in;
         den_ff   <= den_in;
         sn_ff    <= sn_in;
         tn_ff    <= tn_in;
         sn6_ff   <= sn6_in;
         sd6_ff   <= sd6_in;
         tn6_ff   <= tn6_in;
         td6_ff   <= td6_in;
         sn7_ff   <= sn7_in;
         sd7_ff   <= sd7_in;
         tn7_ff   <= tn7_in;
         td7_ff   <= td7_in;
         div_ff   <= div_in;
         su_ff    <= su_in;
         tv_ff    <= tv_in;
         wa_ff    <= div_ff[FW].g.w;
         mag_ff   <= mag_in;
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= mag_ff[i][ssd_pkg::MAG_W-1:ssd_pkg::LO_W]
                      * mag_ff[i][ssd_pkg::MAG_W-1:ssd_pkg::LO_W];
            hl_ff[i] <= mag_ff[i][ssd_pkg::MAG_W-1:ssd_pkg::LO_W]
                      * mag_ff[i][ssd_pkg::LO_W-1:0];
            ll_ff[i] <= mag_ff[i][ssd_pkg::LO_W-1:0] * mag_ff[i][ssd_pkg::LO_W-1:0];
         end
         sq_ff    <= sq_in;
         sum_ff   <= sum_in;
         dist_ff  <= dist_in;
      end
   end

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dist_sq <= ssd_pkg::DIST_MAX)
      else $error("distance above saturation limit");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipe moved during stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted item not in first stage");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_VALID] |-> div_ff[FW].s.rem < div_ff[FW].s.den
                           && div_ff[FW].t.rem < div_ff[FW].t.den)
      else $error("divider remainder out of range");

endmodule
